[hw/rtl/srp_pkg.sv]
// Shared types, constants and the microcode table of the sideband record parser.
package srp_pkg;

    // Item kinds carried in the input sideband
    typedef enum logic [2:0] {
        FN_BEGIN     = 3'd0,
        FN_END       = 3'd1,
        FN_SETTING   = 3'd2,
        FN_INTERVENE = 3'd3,
        FN_TAKE      = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_OFFICIAL  = 4'd1,
        PH_TRANSPORT = 4'd2,
        PH_SCHEMA    = 4'd3,
        PH_LIMITS    = 4'd4,
        PH_CHECKSUM  = 4'd5,
        PH_COMMIT    = 4'd6,
        PH_READY     = 4'd7,
        PH_POISONED  = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ST_INVALID         = 4'd0,
        ST_STARTED         = 4'd1,
        ST_BOUNDARY        = 4'd2,
        ST_ENDED           = 4'd3,
        ST_NOT_SIDEBAND    = 4'd4,
        ST_INTERVENING     = 4'd5,
        ST_UNEXPECTED      = 4'd6,
        ST_UNSUPPORTED     = 4'd7,
        ST_ACCEPTED        = 4'd8,
        ST_CSUM_MISMATCH   = 4'd9,
        ST_COMMIT_MISMATCH = 4'd10,
        ST_COMMITTED       = 4'd11,
        ST_TAKEN           = 4'd12
    } t_status;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_SCHEMA  = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;
    localparam logic [1:0] REG_BASE    = 2'd3;

    localparam logic [31:0] RST_VERSION = 32'd1;
    localparam logic [31:0] RST_SCHEMA  = 32'd65537;
    localparam logic [15:0] RST_LIMIT   = 16'd16;
    localparam logic [31:0] RST_BASE    = 32'd0;

    localparam logic [31:0] FNV_OFFSET    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME     = 32'd16777619;
    localparam logic [31:0] CHECK_DOMAIN  = 32'h574e4243;
    localparam logic [31:0] COMMIT_DOMAIN = 32'h574e4231;

    // Six words of four bytes each go through the hash
    localparam int          HASH_BYTES = 24;
    localparam logic [4:0]  HASH_LAST  = 5'(HASH_BYTES - 1);
    localparam logic [2:0]  LAST_FIELD = 3'd6;

    typedef struct packed {
        logic init;
        logic step;
    } t_fnv_ctl;

    // Microcode
    typedef enum logic [2:0] {
        UOP_FETCH  = 3'd0,
        UOP_DECODE = 3'd1,
        UOP_HINIT  = 3'd2,
        UOP_HSTEP  = 3'd3,
        UOP_HCHECK = 3'd4,
        UOP_EMIT   = 3'd5
    } t_uop;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN_VALID = 3'd1,
        COND_HASH     = 3'd2,
        COND_LOOP     = 3'd3,
        COND_OUT_FREE = 3'd4
    } t_cond;

    typedef struct packed {
        t_uop       op;
        t_cond      cond;
        logic [2:0] t_true;
        logic [2:0] t_false;
    } t_uword;

    localparam logic [2:0] UA_FETCH  = 3'd0;
    localparam logic [2:0] UA_DECODE = 3'd1;
    localparam logic [2:0] UA_HINIT  = 3'd2;
    localparam logic [2:0] UA_HSTEP  = 3'd3;
    localparam logic [2:0] UA_HCHECK = 3'd4;
    localparam logic [2:0] UA_EMIT   = 3'd5;

    function automatic t_uword srp_rom(input logic [2:0] addr);
        t_uword w;
        unique case (addr)
            UA_FETCH:  w = '{UOP_FETCH,  COND_IN_VALID, UA_DECODE, UA_FETCH};
            UA_DECODE: w = '{UOP_DECODE, COND_HASH,     UA_HINIT,  UA_EMIT};
            UA_HINIT:  w = '{UOP_HINIT,  COND_ALWAYS,   UA_HSTEP,  UA_HSTEP};
            UA_HSTEP:  w = '{UOP_HSTEP,  COND_LOOP,     UA_HSTEP,  UA_HCHECK};
            UA_HCHECK: w = '{UOP_HCHECK, COND_ALWAYS,   UA_EMIT,   UA_EMIT};
            UA_EMIT:   w = '{UOP_EMIT,   COND_OUT_FREE, UA_FETCH,  UA_EMIT};
            default:   w = '{UOP_FETCH,  COND_ALWAYS,   UA_FETCH,  UA_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

[hw/rtl/srp_fnv.sv]
// FNV-1a byte step unit: one multiply by the prime per cycle while i_ctl.step is set.
module srp_fnv (
    input  logic               i_clk,
    input  srp_pkg::t_fnv_ctl  i_ctl,
    input  logic [7:0]         i_byte,
    output logic [31:0]        o_hash
);

    logic [31:0] r_hash;
    logic [31:0] mix;
    logic [31:0] prod;

    assign mix  = r_hash ^ {24'd0, i_byte};
    assign prod = mix * srp_pkg::FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_hash <= srp_pkg::FNV_OFFSET;
        end else if (i_ctl.step) begin
            r_hash <= prod;
        end
    end

    assign o_hash = r_hash;

endmodule

[hw/rtl/sideband_record_parser.sv]
// Sideband record parser: top level with microcode sequencer, datapath and ports.
//
// Parses a confirmation record sent as seven consecutive setting transactions
// (version, official epoch, transport epoch, schema word, limit, FNV-1a
// checksum, commit word) inside a packet bracketed by begin and end items, and
// hands out a committed record on a take item. Every input transaction yields
// exactly one output transaction: a status code in m_tuser and, for a take,
// the record in m_tdata (zero otherwise). The block works on one transaction
// at a time under a small microprogram: accept, decode, then emit into the
// output register. The checksum field also runs 24 byte steps through the
// single FNV multiplier plus a setup and a compare step. The next transaction
// is accepted while the previous result still waits in the output register;
// only a second result waiting on a stalled output holds the sequencer.
// Configuration goes through an APB port (registers at byte addresses 0, 4,
// 8, 12) and is meant to be written while no transaction is in flight.
module sideband_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] index, [63:32] value
    input  logic [2:0]  s_tuser,   // [2:0] func
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] rec_official_epoch, [63:32] rec_transport_epoch,
                                   // [95:64] rec_checksum
    output logic [3:0]  m_tuser,   // [3:0] status
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [31:0] r_version;
    logic [31:0] r_schema;
    logic [15:0] r_limit;
    logic [31:0] r_base;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= srp_pkg::RST_VERSION;
            r_schema  <= srp_pkg::RST_SCHEMA;
            r_limit   <= srp_pkg::RST_LIMIT;
            r_base    <= srp_pkg::RST_BASE;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                srp_pkg::REG_VERSION: r_version <= pwdata;
                srp_pkg::REG_SCHEMA:  r_schema  <= pwdata;
                srp_pkg::REG_LIMIT:   r_limit   <= pwdata[15:0];
                srp_pkg::REG_BASE:    r_base    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            srp_pkg::REG_VERSION: prdata = r_version;
            srp_pkg::REG_SCHEMA:  prdata = r_schema;
            srp_pkg::REG_LIMIT:   prdata = {16'd0, r_limit};
            srp_pkg::REG_BASE:    prdata = r_base;
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: one control word per micro-step from the table
    // ---------------------------------------------------------------------
    logic [2:0]      r_upc;
    logic [2:0]      n_upc;
    srp_pkg::t_uword uw;
    logic            cond_met;

    // Held transaction
    srp_pkg::t_func  r_func;
    logic [31:0]     r_index;
    logic [31:0]     r_value;

    // Protocol state
    srp_pkg::t_phase r_phase, n_phase;
    logic            r_open, n_open;
    logic [31:0]     r_pend_off, n_pend_off;
    logic [31:0]     r_pend_tr, n_pend_tr;
    logic [31:0]     r_pend_cs, n_pend_cs;

    // Result waiting for the output register
    srp_pkg::t_status r_res_status, n_res_status;
    logic [31:0]      r_res_off, n_res_off;
    logic [31:0]      r_res_tr, n_res_tr;
    logic [31:0]      r_res_cs, n_res_cs;

    // Output register
    logic             r_m_valid, n_m_valid;
    srp_pkg::t_status r_m_status;
    logic [31:0]      r_m_off, r_m_tr, r_m_cs;

    // Hash byte counter and unit
    logic [4:0]        r_cnt, n_cnt;
    srp_pkg::t_fnv_ctl fnv_ctl;
    logic [31:0]       hash;
    logic [31:0]       hash_word;
    logic [7:0]        hash_byte;

    logic hash_needed;
    logic out_free;

    assign uw       = srp_pkg::srp_rom(r_upc);
    assign s_tready = (uw.op == srp_pkg::UOP_FETCH);
    assign out_free = !r_m_valid || m_tready;

    // ---------------------------------------------------------------------
    // Decode of the held transaction
    // ---------------------------------------------------------------------
    logic [31:0]      off;
    logic             recog;
    logic [31:0]      commit_word;
    srp_pkg::t_status d_status;
    srp_pkg::t_phase  d_phase;
    logic             d_open;
    logic             d_clear;
    logic             d_ld_off;
    logic             d_ld_tr;
    logic             d_take;

    assign off   = r_index - r_base;
    assign recog = (off <= {29'd0, srp_pkg::LAST_FIELD});
    assign commit_word = srp_pkg::COMMIT_DOMAIN ^ srp_pkg::rotl32(r_pend_cs, 7) ^
                         srp_pkg::rotl32(r_pend_off, 13) ^ srp_pkg::rotl32(r_pend_tr, 21);

    assign hash_needed = (r_func == srp_pkg::FN_SETTING) && r_open && recog &&
                         (r_phase == srp_pkg::PH_CHECKSUM) &&
                         (off[3:0] == 4'(srp_pkg::PH_CHECKSUM));

    always_comb begin
        d_status = srp_pkg::ST_INVALID;
        d_phase  = r_phase;
        d_open   = r_open;
        d_clear  = 1'b0;
        d_ld_off = 1'b0;
        d_ld_tr  = 1'b0;
        d_take   = 1'b0;
        unique case (r_func)
            srp_pkg::FN_BEGIN: begin
                d_status = r_open ? srp_pkg::ST_BOUNDARY : srp_pkg::ST_STARTED;
                d_phase  = srp_pkg::PH_IDLE;
                d_clear  = 1'b1;
                d_open   = 1'b1;
            end
            srp_pkg::FN_END: begin
                if (r_open) begin
                    d_status = (r_phase == srp_pkg::PH_IDLE) ? srp_pkg::ST_ENDED
                                                             : srp_pkg::ST_BOUNDARY;
                    d_phase  = srp_pkg::PH_IDLE;
                    d_clear  = 1'b1;
                    d_open   = 1'b0;
                end
            end
            srp_pkg::FN_SETTING: begin
                if (r_open) begin
                    priority if (!recog) begin
                        if (r_phase != srp_pkg::PH_IDLE) begin
                            d_phase  = srp_pkg::PH_POISONED;
                            d_clear  = 1'b1;
                            d_status = srp_pkg::ST_INTERVENING;
                        end else begin
                            d_status = srp_pkg::ST_NOT_SIDEBAND;
                        end
                    end else if (r_phase == srp_pkg::PH_POISONED ||
                                 r_phase == srp_pkg::PH_READY) begin
                        d_phase  = srp_pkg::PH_POISONED;
                        d_clear  = 1'b1;
                        d_status = srp_pkg::ST_UNEXPECTED;
                    end else if (off[2:0] == 3'd0) begin
                        d_clear = 1'b1;
                        priority if (r_phase != srp_pkg::PH_IDLE) begin
                            d_phase  = srp_pkg::PH_POISONED;
                            d_status = srp_pkg::ST_UNEXPECTED;
                        end else if (r_value != r_version) begin
                            d_phase  = srp_pkg::PH_POISONED;
                            d_status = srp_pkg::ST_UNSUPPORTED;
                        end else begin
                            d_phase  = srp_pkg::PH_OFFICIAL;
                            d_status = srp_pkg::ST_ACCEPTED;
                        end
                    end else if ({1'b0, off[2:0]} != r_phase) begin
                        d_phase  = srp_pkg::PH_POISONED;
                        d_clear  = 1'b1;
                        d_status = srp_pkg::ST_UNEXPECTED;
                    end else begin
                        unique case (r_phase)
                            srp_pkg::PH_OFFICIAL: begin
                                d_ld_off = 1'b1;
                                d_phase  = srp_pkg::PH_TRANSPORT;
                                d_status = srp_pkg::ST_ACCEPTED;
                            end
                            srp_pkg::PH_TRANSPORT: begin
                                d_ld_tr  = 1'b1;
                                d_phase  = srp_pkg::PH_SCHEMA;
                                d_status = srp_pkg::ST_ACCEPTED;
                            end
                            srp_pkg::PH_SCHEMA: begin
                                if (r_value != r_schema) begin
                                    d_phase  = srp_pkg::PH_POISONED;
                                    d_clear  = 1'b1;
                                    d_status = srp_pkg::ST_UNSUPPORTED;
                                end else begin
                                    d_phase  = srp_pkg::PH_LIMITS;
                                    d_status = srp_pkg::ST_ACCEPTED;
                                end
                            end
                            srp_pkg::PH_LIMITS: begin
                                if (r_value != {16'd0, r_limit}) begin
                                    d_phase  = srp_pkg::PH_POISONED;
                                    d_clear  = 1'b1;
                                    d_status = srp_pkg::ST_UNSUPPORTED;
                                end else begin
                                    d_phase  = srp_pkg::PH_CHECKSUM;
                                    d_status = srp_pkg::ST_ACCEPTED;
                                end
                            end
                            srp_pkg::PH_COMMIT: begin
                                if (r_pend_off == '0 || r_pend_tr == '0 ||
                                    r_value != commit_word) begin
                                    d_phase  = srp_pkg::PH_POISONED;
                                    d_clear  = 1'b1;
                                    d_status = srp_pkg::ST_COMMIT_MISMATCH;
                                end else begin
                                    d_phase  = srp_pkg::PH_READY;
                                    d_status = srp_pkg::ST_COMMITTED;
                                end
                            end
                            // Checksum field: settled by the hash steps
                            default: ;
                        endcase
                    end
                end
            end
            srp_pkg::FN_INTERVENE: begin
                if (r_open) begin
                    if (r_phase == srp_pkg::PH_IDLE) begin
                        d_status = srp_pkg::ST_NOT_SIDEBAND;
                    end else begin
                        d_phase  = srp_pkg::PH_POISONED;
                        d_clear  = 1'b1;
                        d_status = srp_pkg::ST_INTERVENING;
                    end
                end
            end
            srp_pkg::FN_TAKE: begin
                if (r_open && r_phase == srp_pkg::PH_READY) begin
                    d_take   = 1'b1;
                    d_phase  = srp_pkg::PH_IDLE;
                    d_clear  = 1'b1;
                    d_status = srp_pkg::ST_TAKEN;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Hash byte feed: word by counter[4:2], little-endian byte by counter[1:0]
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (r_cnt[4:2])
            3'd0:    hash_word = srp_pkg::CHECK_DOMAIN;
            3'd1:    hash_word = r_version;
            3'd2:    hash_word = r_pend_off;
            3'd3:    hash_word = r_pend_tr;
            3'd4:    hash_word = r_schema;
            3'd5:    hash_word = {16'd0, r_limit};
            default: hash_word = '0;
        endcase
    end

    assign hash_byte    = hash_word[{r_cnt[1:0], 3'b000} +: 8];
    assign fnv_ctl.init = (uw.op == srp_pkg::UOP_HINIT);
    assign fnv_ctl.step = (uw.op == srp_pkg::UOP_HSTEP);

    srp_fnv u_fnv (
        .i_clk  (i_clk),
        .i_ctl  (fnv_ctl),
        .i_byte (hash_byte),
        .o_hash (hash)
    );

    // ---------------------------------------------------------------------
    // Branch condition and datapath next values
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (uw.cond)
            srp_pkg::COND_ALWAYS:   cond_met = 1'b1;
            srp_pkg::COND_IN_VALID: cond_met = s_tvalid;
            srp_pkg::COND_HASH:     cond_met = hash_needed;
            srp_pkg::COND_LOOP:     cond_met = (r_cnt != srp_pkg::HASH_LAST);
            srp_pkg::COND_OUT_FREE: cond_met = out_free;
            default:                cond_met = 1'b1;
        endcase
        n_upc = cond_met ? uw.t_true : uw.t_false;
    end

    always_comb begin
        n_phase      = r_phase;
        n_open       = r_open;
        n_pend_off   = r_pend_off;
        n_pend_tr    = r_pend_tr;
        n_pend_cs    = r_pend_cs;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_tr     = r_res_tr;
        n_res_cs     = r_res_cs;
        n_cnt        = r_cnt;
        n_m_valid    = r_m_valid;
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (uw.op)
            srp_pkg::UOP_DECODE: begin
                n_phase      = d_phase;
                n_open       = d_open;
                n_res_status = d_status;
                n_res_off    = d_take ? r_pend_off : '0;
                n_res_tr     = d_take ? r_pend_tr  : '0;
                n_res_cs     = d_take ? r_pend_cs  : '0;
                if (d_clear) begin
                    n_pend_off = '0;
                    n_pend_tr  = '0;
                    n_pend_cs  = '0;
                end
                if (d_ld_off) begin
                    n_pend_off = r_value;
                end
                if (d_ld_tr) begin
                    n_pend_tr = r_value;
                end
            end
            srp_pkg::UOP_HINIT: n_cnt = '0;
            srp_pkg::UOP_HSTEP: n_cnt = r_cnt + 5'd1;
            srp_pkg::UOP_HCHECK: begin
                if (r_value != hash) begin
                    n_phase      = srp_pkg::PH_POISONED;
                    n_pend_off   = '0;
                    n_pend_tr    = '0;
                    n_pend_cs    = '0;
                    n_res_status = srp_pkg::ST_CSUM_MISMATCH;
                end else begin
                    n_phase      = srp_pkg::PH_COMMIT;
                    n_pend_cs    = hash;
                    n_res_status = srp_pkg::ST_ACCEPTED;
                end
            end
            srp_pkg::UOP_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc      <= srp_pkg::UA_FETCH;
            r_phase    <= srp_pkg::PH_IDLE;
            r_open     <= 1'b0;
            r_m_valid  <= 1'b0;
            r_pend_off <= '0;
            r_pend_tr  <= '0;
            r_pend_cs  <= '0;
        end else begin
            r_upc      <= n_upc;
            r_phase    <= n_phase;
            r_open     <= n_open;
            r_m_valid  <= n_m_valid;
            r_pend_off <= n_pend_off;
            r_pend_tr  <= n_pend_tr;
            r_pend_cs  <= n_pend_cs;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_tr     <= n_res_tr;
        r_res_cs     <= n_res_cs;
        if (s_tvalid && s_tready) begin
            r_func  <= srp_pkg::t_func'(s_tuser);
            r_index <= s_tdata[31:0];
            r_value <= s_tdata[63:32];
        end
        if (uw.op == srp_pkg::UOP_EMIT && out_free) begin
            r_m_status <= r_res_status;
            r_m_off    <= r_res_off;
            r_m_tr     <= r_res_tr;
            r_m_cs     <= r_res_cs;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_status;
    assign m_tdata  = {r_m_cs, r_m_tr, r_m_off};

endmodule

[hw/rtl/srp_checker.sv]
// Port-level assertions for the sideband record parser and their bind.
module srp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result shown after reset");

    // Record fields carry data only for a take
    a_rec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != srp_pkg::ST_TAKEN) |-> (m_tdata == '0))
        else $error("record fields set on a non-take result");

    // A taken record passed the commit check, so both epochs are non-zero
    a_taken_epochs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == srp_pkg::ST_TAKEN) |->
            (m_tdata[31:0] != '0 && m_tdata[63:32] != '0))
        else $error("taken record with a zero epoch");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind sideband_record_parser srp_checker u_srp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
